// ----- hw/rtl/sdss_pkg.sv -----
// Package for the six-digit seven-segment scanner: digit count, scan width, segment decode.
package sdss_pkg;

    localparam int unsigned NUM_DIGITS = 6;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned VALUE_W    = 10;
    localparam int unsigned SEG_W      = 7;
    localparam int unsigned DIGITS_PER_VALUE = 3;

    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [NUM_DIGITS-1:0] enable_t;
    typedef logic [SEG_W-1:0]      seg_t;
    typedef logic [3:0]            bcd_t;

    localparam pos_t   LAST_POS   = pos_t'(NUM_DIGITS - 1);
    localparam pos_t   FIRST_HIGH = pos_t'(DIGITS_PER_VALUE);
    localparam value_t MOD_VALUE  = value_t'(1000);

    // Active-high pattern, bit0 = segment a .. bit6 = segment g.
    function automatic seg_t seg_decode(input bcd_t d);
        seg_t s;
        begin
            case (d)
                4'd0:    s = 7'h3F;
                4'd1:    s = 7'h06;
                4'd2:    s = 7'h5B;
                4'd3:    s = 7'h4F;
                4'd4:    s = 7'h66;
                4'd5:    s = 7'h6D;
                4'd6:    s = 7'h7D;
                4'd7:    s = 7'h07;
                4'd8:    s = 7'h7F;
                4'd9:    s = 7'h6F;
                default: s = 7'h3F;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- hw/rtl/six_digit_seven_segment_scan.sv -----
// Six-digit multiplexed seven-segment scanner: top level.
// Each accepted request is one refresh tick and yields one result: a one-hot digit
// enable and the segment pattern for that digit. Digits 0..2 show units, tens and
// hundreds of first_value, digits 3..5 those of second_value, both modulo 1000 with
// leading zeros. The scan position starts at digit 0 after reset and advances by one
// per request, wrapping after digit 5. The result passes through the input register,
// the place-select register and the result register; one request is taken every
// cycle as long as the result side keeps up.
module six_digit_seven_segment_scan (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  sdss_pkg::value_t        first_value,
    input  sdss_pkg::value_t        second_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output sdss_pkg::enable_t       digit_enable,
    output sdss_pkg::seg_t          segments
);
    import sdss_pkg::*;

    pos_t    scan_pos_reg, scan_pos_next;

    logic    s1_valid_reg;
    value_t  first_s1_reg;
    value_t  second_s1_reg;
    pos_t    pos_s1_reg;

    logic    s2_valid_reg;
    value_t  place_s2_reg;
    enable_t enable_s2_reg;

    logic    out_valid_reg;
    enable_t enable_out_reg;
    seg_t    seg_out_reg;

    logic    s1_ready, s2_ready, out_load;
    logic    in_accept;

    value_t          sel_value, mod_value;
    logic [1:0]      place;
    logic [17:0]     prod10;
    logic [15:0]     prod100;
    logic [6:0]      quot10;
    logic [3:0]      quot100;
    value_t          place_value;

    logic [17:0]     prod_digit;
    logic [6:0]      quot_digit;
    value_t          tens_part;
    bcd_t            digit;

    assign out_load  = !out_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || out_load;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (scan_pos_reg >= LAST_POS)
        begin
            scan_pos_next = '0;
        end
        else
        begin
            scan_pos_next = scan_pos_reg + pos_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                scan_pos_reg <= scan_pos_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: capture the request and the digit it drives.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            first_s1_reg  <= first_value;
            second_s1_reg <= second_value;
            pos_s1_reg    <= (scan_pos_reg > LAST_POS) ? pos_t'(0) : scan_pos_reg;
        end
    end

    // Stage 2: pick the number, reduce modulo 1000, take the place quotient.
    always_comb
    begin
        if (pos_s1_reg < FIRST_HIGH)
        begin
            sel_value = first_s1_reg;
            place     = pos_s1_reg[1:0];
        end
        else
        begin
            sel_value = second_s1_reg;
            place     = 2'(pos_s1_reg - FIRST_HIGH);
        end

        mod_value = (sel_value >= MOD_VALUE) ? value_t'(sel_value - MOD_VALUE) : sel_value;

        // v/10 and v/100 by reciprocal, exact for v < 1000
        prod10  = 18'(mod_value) * 18'(205);
        prod100 = 16'(mod_value) * 16'(41);
        quot10  = 7'(prod10 >> 11);
        quot100 = 4'(prod100 >> 12);

        case (place)
            2'd1:    place_value = value_t'(quot10);
            2'd2:    place_value = value_t'(quot100);
            default: place_value = mod_value;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            place_s2_reg  <= place_value;
            enable_s2_reg <= enable_t'(1) << pos_s1_reg;
        end
    end

    // Stage 3: last decimal digit and segment decode.
    always_comb
    begin
        prod_digit = 18'(place_s2_reg) * 18'(205);
        quot_digit = 7'(prod_digit >> 11);
        tens_part  = value_t'(quot_digit) * value_t'(10);
        digit      = 4'(place_s2_reg - tens_part);
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s2_valid_reg)
        begin
            enable_out_reg <= enable_s2_reg;
            seg_out_reg    <= seg_decode(digit);
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_enable = enable_out_reg;
    assign segments     = seg_out_reg;

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_pos_reg <= LAST_POS)
        else $error("scan position out of range");

    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(enable_out_reg))
        else $error("digit enable not one-hot");

    a_segments_lit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (seg_out_reg != '0))
        else $error("blank segment pattern");

    a_place_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (place_s2_reg < MOD_VALUE))
        else $error("place value not reduced");

    a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && scan_pos_reg != LAST_POS)
            |=> (scan_pos_reg == $past(scan_pos_reg) + pos_t'(1)))
        else $error("scan position did not advance");

endmodule
